/* rtl/sgca_pkg.sv */
// Shared constants and field layout for the staggered grid corner averager.
package sgca_pkg;

   localparam int MAX_POINTS_X = 128;
   localparam int MAX_POINTS_Y = 128;
   localparam int SAMPLE_WIDTH = 32;

   localparam int X_W      = $clog2(MAX_POINTS_X);
   localparam int Y_W      = $clog2(MAX_POINTS_Y);
   localparam int NX_W     = $clog2(MAX_POINTS_X + 1);
   localparam int NY_W     = $clog2(MAX_POINTS_Y + 1);
   localparam int PLANE_AW = X_W + Y_W;

   localparam int PX_W     = 8;
   localparam int PY_W     = 8;
   localparam int PZ_W     = 16;
   localparam int POS_XY_W = 7;
   localparam int POS_Z_W  = 16;
   localparam int MASK_W   = 7;

   localparam int SUM2_W = SAMPLE_WIDTH + 1;
   localparam int SUM4_W = SAMPLE_WIDTH + 2;
   localparam int SUM8_W = SAMPLE_WIDTH + 3;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REG_POINTS_X = 2'd0;
   localparam logic [1:0] REG_POINTS_Y = 2'd1;
   localparam logic [1:0] REG_POINTS_Z = 2'd2;

   localparam logic [PX_W-1:0] POINTS_X_RESET = PX_W'(128);
   localparam logic [PY_W-1:0] POINTS_Y_RESET = PY_W'(128);
   localparam logic [PZ_W-1:0] POINTS_Z_RESET = PZ_W'(128);

   localparam int REQ_W     = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS  = 2 * POS_XY_W + POS_Z_W + MASK_W + 7 * SAMPLE_WIDTH;
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD   = RSP_W - RSP_BITS;
   localparam int REQ_PAD   = REQ_W - SAMPLE_WIDTH;

endpackage

/* rtl/staggered_grid_corner_average.sv */
// Top level of the staggered grid corner averager: 2x2x2 box means over a raster stream.
//
//  channel  | direction | handshake              | payload
//  req_     | in        | tvalid / tready        | tdata: sample_value
//  rsp_     | out       | tvalid / tready        | tdata: positions, mask, seven means; tlast
//  csr_     | in        | psel / penable, pready | points_x, points_y, points_z
//
// One word per cycle while rsp_ is not stalled; a sample passes the read, sum and output registers.
// The rate is set by the plane and row RAMs, each read once and written once per word.
// Reset clears the cursors, the pipeline valids and restores the grid sizes to 128.
// A stalled rsp_ side holds the output register, then the sum and read stages in turn.
// A write to a size register restarts the volume at the origin.
module staggered_grid_corner_average
   import sgca_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_W-1:0]        req_tdata,   // sample_value
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // pos_x, pos_y, pos_z, valid_mask, edge_x_mean, edge_y_mean, edge_z_mean,
   // face_x_mean, face_y_mean, face_z_mean, cell_mean, zero pad
   output logic [RSP_W-1:0]        rsp_tdata,
   output logic                    rsp_tlast,   // last_point
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_AW-1:0]       csr_paddr,
   input  logic [CSR_DW-1:0]       csr_pwdata,
   output logic [CSR_DW-1:0]       csr_prdata,
   output logic                    csr_pready
);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   // configuration
   logic [PX_W-1:0] points_x_ff, points_x_in;
   logic [PY_W-1:0] points_y_ff, points_y_in;
   logic [PZ_W-1:0] points_z_ff, points_z_in;
   logic            csr_wr;
   logic            restart;
   logic [1:0]      csr_idx;

   logic [NX_W-1:0] nx;
   logic [NY_W-1:0] ny;
   logic [PZ_W-1:0] nz;

   // cursor
   logic [X_W-1:0]  cursor_x_ff, cursor_x_in;
   logic [Y_W-1:0]  cursor_y_ff, cursor_y_in;
   logic [PZ_W-1:0] cursor_z_ff, cursor_z_in;
   logic            x_end, y_end, z_end;

   // handshake
   logic accept, s1_move, s2_move, s2_space, out_space;

   // read stage
   logic            s1_valid_ff, s1_valid_in;
   sample_type      s1_sample_ff;
   logic [X_W-1:0]  s1_x_ff;
   logic [Y_W-1:0]  s1_y_ff;
   logic [PZ_W-1:0] s1_z_ff;
   logic            s1_bx_ff, s1_by_ff, s1_bz_ff, s1_last_ff;

   logic [SAMPLE_WIDTH-1:0]   plane_rd;
   logic [2*SAMPLE_WIDTH-1:0] row_rd;
   sample_type                pl, pr, prp;
   sample_type                l0_ff, l1_ff, l2_ff, l3_ff;

   // sum stage
   logic                     s2_valid_ff, s2_valid_in;
   logic signed [SUM2_W-1:0] s2_ex_ff, s2_ey_ff, s2_ez_ff;
   logic signed [SUM4_W-1:0] s2_fx_ff, s2_fy_ff, s2_fz_ff, s2_lsum_ff;
   logic [X_W-1:0]           s2_x_ff;
   logic [Y_W-1:0]           s2_y_ff;
   logic [PZ_W-1:0]          s2_z_ff;
   logic [MASK_W-1:0]        s2_mask_ff;
   logic                     s2_last_ff;

   // output register
   logic                     out_valid_ff, out_valid_in;
   logic [POS_XY_W-1:0]      out_x_ff, out_y_ff;
   logic [POS_Z_W-1:0]       out_z_ff;
   logic [MASK_W-1:0]        out_mask_ff, s1_mask;
   logic                     out_last_ff;
   sample_type               out_ex_ff, out_ey_ff, out_ez_ff;
   sample_type               out_fx_ff, out_fy_ff, out_fz_ff, out_cell_ff;

   logic signed [SUM2_W-1:0] ex_sh, ey_sh, ez_sh;
   logic signed [SUM4_W-1:0] fx_sh, fy_sh, fz_sh;
   logic signed [SUM8_W-1:0] cell_sum, cell_sh;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      points_x_in = points_x_ff;
      points_y_in = points_y_ff;
      points_z_in = points_z_ff;
      restart     = 1'b0;
      csr_prdata  = '0;
      unique case (csr_idx)
         REG_POINTS_X: begin
            csr_prdata = CSR_DW'(points_x_ff);
            if (csr_wr) begin
               points_x_in = csr_pwdata[PX_W-1:0];
               restart     = 1'b1;
            end
         end
         REG_POINTS_Y: begin
            csr_prdata = CSR_DW'(points_y_ff);
            if (csr_wr) begin
               points_y_in = csr_pwdata[PY_W-1:0];
               restart     = 1'b1;
            end
         end
         REG_POINTS_Z: begin
            csr_prdata = CSR_DW'(points_z_ff);
            if (csr_wr) begin
               points_z_in = csr_pwdata[PZ_W-1:0];
               restart     = 1'b1;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // clamp sizes
   always_comb begin
      if (32'(points_x_ff) < 2) begin
         nx = NX_W'(2);
      end else if (32'(points_x_ff) > MAX_POINTS_X) begin
         nx = NX_W'(MAX_POINTS_X);
      end else begin
         nx = NX_W'(points_x_ff);
      end
      if (32'(points_y_ff) < 2) begin
         ny = NY_W'(2);
      end else if (32'(points_y_ff) > MAX_POINTS_Y) begin
         ny = NY_W'(MAX_POINTS_Y);
      end else begin
         ny = NY_W'(points_y_ff);
      end
      if (points_z_ff < PZ_W'(2)) begin
         nz = PZ_W'(2);
      end else begin
         nz = points_z_ff;
      end
   end

   // cursor advance
   assign x_end = (32'(cursor_x_ff) == 32'(nx) - 1);
   assign y_end = (32'(cursor_y_ff) == 32'(ny) - 1);
   assign z_end = (32'(cursor_z_ff) == 32'(nz) - 1);

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      cursor_z_in = cursor_z_ff;
      if (restart) begin
         cursor_x_in = '0;
         cursor_y_in = '0;
         cursor_z_in = '0;
      end else if (accept) begin
         if (!x_end) begin
            cursor_x_in = X_W'(cursor_x_ff + 1'b1);
         end else if (!y_end) begin
            cursor_x_in = '0;
            cursor_y_in = Y_W'(cursor_y_ff + 1'b1);
         end else if (!z_end) begin
            cursor_x_in = '0;
            cursor_y_in = '0;
            cursor_z_in = PZ_W'(cursor_z_ff + 1'b1);
         end else begin
            cursor_x_in = '0;
            cursor_y_in = '0;
            cursor_z_in = '0;
         end
      end
   end

   // pipeline flow
   assign out_space  = !out_valid_ff || rsp_tready;
   assign s2_move    = s2_valid_ff && out_space;
   assign s2_space   = !s2_valid_ff || out_space;
   assign s1_move    = s1_valid_ff && s2_space;
   assign req_tready = !s1_valid_ff || s2_space;
   assign accept     = req_tvalid && req_tready;

   assign s1_valid_in  = req_tready ? accept : s1_valid_ff;
   assign s2_valid_in  = s2_space ? s1_move : s2_valid_ff;
   assign out_valid_in = out_space ? s2_move : out_valid_ff;

   // state memories
   sgca_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (1 << PLANE_AW)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr ({s1_y_ff, s1_x_ff}),
      .wr_data (s1_sample_ff),
      .rd_en   (accept),
      .rd_addr ({cursor_y_ff, cursor_x_ff}),
      .rd_data (plane_rd)
   );

   // row word holds {prev row prev plane, prev row}
   sgca_ram #(
      .WIDTH (2 * SAMPLE_WIDTH),
      .DEPTH (1 << X_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_x_ff),
      .wr_data ({plane_rd, s1_sample_ff}),
      .rd_en   (accept),
      .rd_addr (cursor_x_ff),
      .rd_data (row_rd)
   );

   assign pl  = plane_rd;
   assign pr  = row_rd[SAMPLE_WIDTH-1:0];
   assign prp = row_rd[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

   assign s1_mask = {s1_bx_ff & s1_by_ff & s1_bz_ff, s1_bx_ff & s1_by_ff,
                     s1_bx_ff & s1_bz_ff, s1_by_ff & s1_bz_ff,
                     s1_bz_ff, s1_by_ff, s1_bx_ff};

   // final sums and floor shifts
   assign cell_sum = SUM8_W'(s2_fx_ff) + SUM8_W'(s2_lsum_ff);
   assign ex_sh    = s2_ex_ff >>> 1;
   assign ey_sh    = s2_ey_ff >>> 1;
   assign ez_sh    = s2_ez_ff >>> 1;
   assign fx_sh    = s2_fx_ff >>> 2;
   assign fy_sh    = s2_fy_ff >>> 2;
   assign fz_sh    = s2_fz_ff >>> 2;
   assign cell_sh  = cell_sum >>> 3;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_x_ff  <= POINTS_X_RESET;
         points_y_ff  <= POINTS_Y_RESET;
         points_z_ff  <= POINTS_Z_RESET;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         cursor_z_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         points_x_ff  <= points_x_in;
         points_y_ff  <= points_y_in;
         points_z_ff  <= points_z_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         cursor_z_ff  <= cursor_z_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_tdata[SAMPLE_WIDTH-1:0];
         s1_x_ff      <= cursor_x_ff;
         s1_y_ff      <= cursor_y_ff;
         s1_z_ff      <= cursor_z_ff;
         s1_bx_ff     <= (cursor_x_ff != '0);
         s1_by_ff     <= (cursor_y_ff != '0);
         s1_bz_ff     <= (cursor_z_ff != '0);
         s1_last_ff   <= x_end & y_end & z_end;
      end
      if (s1_move) begin
         l0_ff      <= s1_sample_ff;
         l1_ff      <= pr;
         l2_ff      <= pl;
         l3_ff      <= prp;
         s2_ex_ff   <= SUM2_W'(s1_sample_ff) + SUM2_W'(l0_ff);
         s2_ey_ff   <= SUM2_W'(s1_sample_ff) + SUM2_W'(pr);
         s2_ez_ff   <= SUM2_W'(s1_sample_ff) + SUM2_W'(pl);
         s2_fx_ff   <= SUM4_W'(SUM2_W'(s1_sample_ff) + SUM2_W'(pr))
                     + SUM4_W'(SUM2_W'(pl) + SUM2_W'(prp));
         s2_fy_ff   <= SUM4_W'(SUM2_W'(s1_sample_ff) + SUM2_W'(l0_ff))
                     + SUM4_W'(SUM2_W'(pl) + SUM2_W'(l2_ff));
         s2_fz_ff   <= SUM4_W'(SUM2_W'(s1_sample_ff) + SUM2_W'(l0_ff))
                     + SUM4_W'(SUM2_W'(pr) + SUM2_W'(l1_ff));
         s2_lsum_ff <= SUM4_W'(SUM2_W'(l0_ff) + SUM2_W'(l1_ff))
                     + SUM4_W'(SUM2_W'(l2_ff) + SUM2_W'(l3_ff));
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_z_ff    <= s1_z_ff;
         s2_mask_ff <= s1_mask;
         s2_last_ff <= s1_last_ff;
      end
      if (s2_move) begin
         out_x_ff    <= POS_XY_W'(s2_x_ff);
         out_y_ff    <= POS_XY_W'(s2_y_ff);
         out_z_ff    <= POS_Z_W'(s2_z_ff);
         out_mask_ff <= s2_mask_ff;
         out_last_ff <= s2_last_ff;
         out_ex_ff   <= s2_mask_ff[0] ? ex_sh[SAMPLE_WIDTH-1:0] : '0;
         out_ey_ff   <= s2_mask_ff[1] ? ey_sh[SAMPLE_WIDTH-1:0] : '0;
         out_ez_ff   <= s2_mask_ff[2] ? ez_sh[SAMPLE_WIDTH-1:0] : '0;
         out_fx_ff   <= s2_mask_ff[3] ? fx_sh[SAMPLE_WIDTH-1:0] : '0;
         out_fy_ff   <= s2_mask_ff[4] ? fy_sh[SAMPLE_WIDTH-1:0] : '0;
         out_fz_ff   <= s2_mask_ff[5] ? fz_sh[SAMPLE_WIDTH-1:0] : '0;
         out_cell_ff <= s2_mask_ff[6] ? cell_sh[SAMPLE_WIDTH-1:0] : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, out_cell_ff, out_fz_ff, out_fy_ff, out_fx_ff,
                        out_ez_ff, out_ey_ff, out_ex_ff, out_mask_ff, out_z_ff,
                        out_y_ff, out_x_ff};

   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      (32'(cursor_x_ff) < 32'(nx)) && (32'(cursor_y_ff) < 32'(ny)) && (cursor_z_ff < nz))
      else $error("cursor outside grid");

   a_last_full_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (out_mask_ff == {MASK_W{1'b1}}))
      else $error("last point without a full mask");

   a_cell_implies_all: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_mask_ff[6] |-> (&out_mask_ff[5:0]))
      else $error("cell mean flagged without its faces and edges");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word lost before read stage");

endmodule

/* rtl/sgca_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module sgca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* dv/sgca_checker.sv */
// Checker for the staggered grid corner averager: predicts each result word and compares it.
`timescale 1ns / 1ps

module sgca_checker
   import sgca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,
   input  logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                mismatch_count,
   output int                averages_owed
);

   localparam int EDGE_X     = 0;
   localparam int EDGE_Y     = 1;
   localparam int EDGE_Z     = 2;
   localparam int FACE_X     = 3;
   localparam int FACE_Y     = 4;
   localparam int FACE_Z     = 5;
   localparam int CELL       = 6;
   localparam int MEAN_COUNT = 7;

   localparam int OFF_Y    = POS_XY_W;
   localparam int OFF_Z    = 2 * POS_XY_W;
   localparam int OFF_MASK = OFF_Z + POS_Z_W;
   localparam int OFF_AVG  = OFF_MASK + MASK_W;

   typedef struct packed {
      logic                                    last;
      logic [MEAN_COUNT-1:0][SAMPLE_WIDTH-1:0] avg;
      logic [MASK_W-1:0]                       mask;
      logic [POS_Z_W-1:0]                      pz;
      logic [POS_XY_W-1:0]                     py;
      logic [POS_XY_W-1:0]                     px;
   } corner_avg_type;

   string mean_label [MEAN_COUNT] = '{"edge_x_mean", "edge_y_mean", "edge_z_mean",
      "face_x_mean", "face_y_mean", "face_z_mean", "cell_mean"};

   logic [PX_W-1:0] size_x = POINTS_X_RESET;
   logic [PY_W-1:0] size_y = POINTS_Y_RESET;
   logic [PZ_W-1:0] size_z = POINTS_Z_RESET;

   logic signed [SAMPLE_WIDTH-1:0] plane_vals [MAX_POINTS_X*MAX_POINTS_Y] = '{default: '0};
   logic signed [SAMPLE_WIDTH-1:0] row_vals [MAX_POINTS_X] = '{default: '0};
   logic signed [SAMPLE_WIDTH-1:0] row_plane_vals [MAX_POINTS_X] = '{default: '0};
   logic signed [SAMPLE_WIDTH-1:0] left_vals [4] = '{default: '0};
   logic [POS_XY_W-1:0] cur_x = '0;
   logic [POS_XY_W-1:0] cur_y = '0;
   logic [POS_Z_W-1:0]  cur_z = '0;

   corner_avg_type owed_avgs [$];

   initial begin
      mismatch_count = 0;
      averages_owed  = 0;
   end

   function automatic int unsigned clamp_span(input logic [PZ_W-1:0] v, input int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic corner_avg_type average_corners(
      input logic signed [SAMPLE_WIDTH-1:0] sample);
      corner_avg_type r;
      int unsigned nx, ny, nz, x, y, z, pidx;
      longint s, pl, pr, prp, l0, l1, l2, l3;
      longint sums [MEAN_COUNT];
      logic bx, by, bz;
      nx = clamp_span(PZ_W'(size_x), MAX_POINTS_X);
      ny = clamp_span(PZ_W'(size_y), MAX_POINTS_Y);
      nz = clamp_span(size_z, 65535);
      x = cur_x;
      y = cur_y;
      z = cur_z;
      if (x >= nx) x = 0;
      if (y >= ny) y = 0;
      if (z >= nz) z = 0;
      pidx = y * MAX_POINTS_X + x;
      s   = sample;
      pl  = plane_vals[pidx];
      pr  = row_vals[x];
      prp = row_plane_vals[x];
      l0  = left_vals[0];
      l1  = left_vals[1];
      l2  = left_vals[2];
      l3  = left_vals[3];
      bx = x >= 1;
      by = y >= 1;
      bz = z >= 1;
      r.mask = '0;
      r.mask[EDGE_X] = bx;
      r.mask[EDGE_Y] = by;
      r.mask[EDGE_Z] = bz;
      r.mask[FACE_X] = by && bz;
      r.mask[FACE_Y] = bx && bz;
      r.mask[FACE_Z] = bx && by;
      r.mask[CELL]   = bx && by && bz;
      sums[EDGE_X] = s + l0;
      sums[EDGE_Y] = s + pr;
      sums[EDGE_Z] = s + pl;
      sums[FACE_X] = s + pr + pl + prp;
      sums[FACE_Y] = s + l0 + pl + l2;
      sums[FACE_Z] = s + l0 + pr + l1;
      sums[CELL]   = s + pr + pl + prp + l0 + l1 + l2 + l3;
      for (int i = 0; i < MEAN_COUNT; i++) begin
         r.avg[i] = r.mask[i] ?
            SAMPLE_WIDTH'(sums[i] >>> (i < FACE_X ? 1 : (i < CELL ? 2 : 3))) : '0;
      end
      r.px   = x[POS_XY_W-1:0];
      r.py   = y[POS_XY_W-1:0];
      r.pz   = z[POS_Z_W-1:0];
      r.last = (x == nx - 1) && (y == ny - 1) && (z == nz - 1);

      row_plane_vals[x] = pl[SAMPLE_WIDTH-1:0];
      row_vals[x]       = sample;
      plane_vals[pidx]  = sample;
      left_vals[0]      = sample;
      left_vals[1]      = pr[SAMPLE_WIDTH-1:0];
      left_vals[2]      = pl[SAMPLE_WIDTH-1:0];
      left_vals[3]      = prp[SAMPLE_WIDTH-1:0];

      if (x + 1 < nx) begin
         cur_x = POS_XY_W'(x + 1);
         cur_y = POS_XY_W'(y);
         cur_z = POS_Z_W'(z);
      end else if (y + 1 < ny) begin
         cur_x = '0;
         cur_y = POS_XY_W'(y + 1);
         cur_z = POS_Z_W'(z);
      end else if (z + 1 < nz) begin
         cur_x = '0;
         cur_y = '0;
         cur_z = POS_Z_W'(z + 1);
      end else begin
         cur_x = '0;
         cur_y = '0;
         cur_z = '0;
      end
      return r;
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      corner_avg_type want, got;
      if (reset) begin
         size_x = POINTS_X_RESET;
         size_y = POINTS_Y_RESET;
         size_z = POINTS_Z_RESET;
         cur_x  = '0;
         cur_y  = '0;
         cur_z  = '0;
         owed_avgs.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr >> 2)
               REG_POINTS_X: begin
                  size_x = csr_pwdata[PX_W-1:0];
                  cur_x = '0; cur_y = '0; cur_z = '0;
               end
               REG_POINTS_Y: begin
                  size_y = csr_pwdata[PY_W-1:0];
                  cur_x = '0; cur_y = '0; cur_z = '0;
               end
               REG_POINTS_Z: begin
                  size_z = csr_pwdata[PZ_W-1:0];
                  cur_x = '0; cur_y = '0; cur_z = '0;
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            owed_avgs.push_back(average_corners(req_tdata[SAMPLE_WIDTH-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got.px   = rsp_tdata[POS_XY_W-1:0];
            got.py   = rsp_tdata[OFF_Y +: POS_XY_W];
            got.pz   = rsp_tdata[OFF_Z +: POS_Z_W];
            got.mask = rsp_tdata[OFF_MASK +: MASK_W];
            for (int i = 0; i < MEAN_COUNT; i++)
               got.avg[i] = rsp_tdata[OFF_AVG + i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            got.last = rsp_tlast;
            if (owed_avgs.size() == 0) begin
               $display("%0t: result word expected none, got %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = owed_avgs.pop_front();
               check_field("pos_x", want.px, got.px);
               check_field("pos_y", want.py, got.py);
               check_field("pos_z", want.pz, got.pz);
               check_field("valid_mask", want.mask, got.mask);
               for (int i = 0; i < MEAN_COUNT; i++)
                  check_field(mean_label[i], want.avg[i], got.avg[i]);
               check_field("last_point", want.last, got.last);
            end
         end
      end
      averages_owed = owed_avgs.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top for the staggered grid corner averager: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
   import sgca_pkg::*;

   localparam int REG_UNUSED  = 3;
   localparam int CYCLE_LIMIT = 100000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tlast;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int          mismatch_count;
   int          averages_owed;
   bit          idle_on     = 1'b1;
   int          stall_left  = 0;
   int unsigned cycle_count = 0;

   staggered_grid_corner_average dut (.*);

   sgca_checker grid_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(input int index, input int unsigned value, input int width);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(index * 4);
      csr_pwdata  <= ($urandom_range(0, 1) ? ($urandom() << width) : 32'd0) | value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [31:0] v);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(v);
      do @(posedge clock); while (!req_tready);
   endtask

   // hold until every owed word has arrived
   task automatic drain_averages();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (averages_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 7)) - 32'd4;
         default: return $urandom();
      endcase
   endfunction

   function automatic int unsigned pick_xy();
      case ($urandom_range(0, 15))
         0: return 0;
         1: return 1;
         2: return 127;
         3: return 128;
         4: return 255;
         default: return $urandom_range(2, 4);
      endcase
   endfunction

   function automatic int unsigned pick_z();
      case ($urandom_range(0, 15))
         0: return 0;
         1: return 1;
         2: return 65535;
         default: return $urandom_range(2, 3);
      endcase
   endfunction

   function automatic int unsigned span_of(input int unsigned v, input int unsigned hi);
      return v < 2 ? 2 : (v > hi ? hi : v);
   endfunction

   initial begin
      int unsigned nx, ny, nz, vol, run_len, split;
      int n_sent;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_POINTS_X, 2, PX_W);
      write_reg(REG_POINTS_Y, 2, PY_W);
      write_reg(REG_POINTS_Z, 2, PZ_W);
      repeat (8) send_sample(32'h7FFF_FFFF);
      repeat (8) send_sample(32'h8000_0000);
      drain_averages();
      write_reg(REG_POINTS_X, 0, PX_W);
      write_reg(REG_POINTS_Y, 1, PY_W);
      write_reg(REG_POINTS_Z, 0, PZ_W);
      for (int i = 0; i < 8; i++)
         send_sample(i[0] ? 32'h0000_0001 : 32'hFFFF_FFFF);
      drain_averages();

      nx = 2; ny = 2; nz = 2;
      n_sent = 0;
      while (n_sent < 400) begin
         idle_on = (n_sent < 330) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            nx = pick_xy();
            ny = pick_xy();
            nz = pick_z();
            write_reg(REG_POINTS_X, nx, PX_W);
            write_reg(REG_POINTS_Y, ny, PY_W);
            write_reg(REG_POINTS_Z, nz, PZ_W);
         end
         vol = span_of(nx, MAX_POINTS_X) * span_of(ny, MAX_POINTS_Y) * span_of(nz, 65535);
         run_len = (vol <= 80) ? $urandom_range(vol / 2 + 1, 2 * vol) : $urandom_range(20, 60);
         split = ($urandom_range(0, 3) == 0) ? run_len / 2 : run_len;
         for (int i = 0; i < run_len; i++) begin
            if (i == split) begin
               // the unused index must leave the volume running
               drain_averages();
               write_reg(REG_UNUSED, $urandom(), 32);
            end
            send_sample(pick_sample());
         end
         n_sent += run_len;
         drain_averages();
      end

      idle_on = 1'b0;
      drain_averages();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && averages_owed == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
rtl/sgca_pkg.sv
rtl/sgca_ram.sv
rtl/staggered_grid_corner_average.sv
dv/sgca_checker.sv
dv/tb.sv
